// ----- rtl/srst_pkg.sv -----
// Shared widths, constants and codes for the stepper ramp step timer.
package srst_pkg;

  localparam int RATE_W = 24;
  localparam int STEP_W = 32;
  localparam int LEVEL_W = 16;
  localparam int POS_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PLAN_CODE_W = 3;
  localparam int PLAN_ENTRIES = 8;
  localparam int PLAN_W = PLAN_CODE_W * PLAN_ENTRIES;
  localparam int PLAN_DEPTH_DEFAULT = 8;

  localparam logic [RATE_W-1:0] RATE_MAX = 24'hFFFFFF;

  localparam int Q16_W = 15;
  localparam logic [Q16_W-1:0] FIRST_STEP_Q16 = 15'd26581;
  localparam int MUL_ACC_W = RATE_W + Q16_W;

  localparam int DIV_DVD_W = RATE_W + 1;
  localparam int DIV_DVS_W = LEVEL_W + 2;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic [PLAN_CODE_W-1:0] PH_ACCEL = 3'd1;
  localparam logic [PLAN_CODE_W-1:0] PH_CRUISE = 3'd2;
  localparam logic [PLAN_CODE_W-1:0] PH_DECEL = 3'd3;
  localparam logic [PLAN_CODE_W-1:0] PH_CRUISE_ALT = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_STEPS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_END = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_LEVEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_LEVEL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_END_RATE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_PLAN = 3'd7;

endpackage

// ----- rtl/srst_serial_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module srst_serial_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [srst_pkg::DIV_DVD_W-1:0]  dividend,
  input  logic [srst_pkg::DIV_DVS_W-1:0]  divisor,
  output logic                            done,
  output logic [srst_pkg::DIV_DVD_W-1:0]  quotient
);
  import srst_pkg::*;

  localparam int CNT_W = $clog2(DIV_DVD_W);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIV_DVD_W-1:0]  dvd;
  logic [DIV_DVS_W-1:0]  rem;
  logic [DIV_DVS_W:0]    trial;
  logic [DIV_DVS_W:0]    diff;
  logic                  ge;

  always_comb begin
    trial = {rem, dvd[DIV_DVD_W-1]};
    ge = trial >= {1'b0, divisor};
    diff = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd <= {dvd[DIV_DVD_W-2:0], 1'b0};
      rem <= ge ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
      quotient <= {quotient[DIV_DVD_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/srst_serial_mul.sv -----
// Shift-and-add multiplier by the first-step Q16 factor, one factor bit per cycle.
module srst_serial_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [srst_pkg::RATE_W-1:0]  multiplicand,
  output logic                         done,
  output logic [srst_pkg::RATE_W-1:0]  product_q16
);
  import srst_pkg::*;

  localparam int CNT_W = $clog2(Q16_W);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [Q16_W-1:0]      cbits;
  logic [RATE_W-1:0]     mcand;
  logic [MUL_ACC_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(Q16_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= multiplicand;
      cbits <= FIRST_STEP_Q16;
      acc <= '0;
    end else if (busy) begin
      cbits <= {cbits[Q16_W-2:0], 1'b0};
      acc <= {acc[MUL_ACC_W-2:0], 1'b0}
             + (cbits[Q16_W-1] ? MUL_ACC_W'(mcand) : '0);
    end
  end

  assign product_q16 = {1'b0, acc[MUL_ACC_W-1:16]};

endmodule

// ----- rtl/stepper_ramp_step_timer_core.sv -----
// Stepper ramp step timer: sequencer, configuration registers and output register.
// A start item goes from the idle state to the done state; a step tick passes through the phase
// state, then the serial multiplier on the first acceleration step or the serial divider on
// other ramp steps that compute a new interval, and then the done state, which loads the output.
// One item is in work at a time: the input is ready only in the idle state.
// Synchronous reset clears all configuration registers, the ramp state and the output valid.
module stepper_ramp_step_timer_core #(
  parameter int PLAN_DEPTH = srst_pkg::PLAN_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // start_rate [23:0], move_reverse [24], zero fill [31:25]
  input  logic [31:0]                       s_axis_tdata,
  // action [0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // timer_period [23:0], position [55:24]
  output logic [55:0]                       m_axis_tdata,
  // timer_stop [0]
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srst_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import srst_pkg::*;

  localparam int IDXW = (PLAN_DEPTH > 1) ? $clog2(PLAN_DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PHASE = 3'd1;
  localparam logic [2:0] S_MUL = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]              state;

  logic [STEP_W-1:0]       total_steps;
  logic [STEP_W-1:0]       accel_end_step;
  logic [STEP_W-1:0]       decel_start_step;
  logic [RATE_W-1:0]       cruise_rate;
  logic [LEVEL_W-1:0]      top_level;
  logic [LEVEL_W-1:0]      end_level;
  logic [RATE_W-1:0]       end_rate;
  logic [PLAN_W-1:0]       phase_plan;

  logic [STEP_W-1:0]       step_count;
  logic [RATE_W-1:0]       interval;
  logic [LEVEL_W-1:0]      ramp_level;
  logic [IDXW-1:0]         plan_index;
  logic [RATE_W-1:0]       saved_accel_rate;
  logic [POS_W-1:0]        axis_position;
  logic                    reverse_dir;

  logic [RATE_W-1:0]       res_period;
  logic                    res_stop;

  logic                    mul_start;
  logic                    mul_done;
  logic [RATE_W-1:0]       mul_product;
  logic                    div_start;
  logic                    div_done;
  logic                    div_sub;
  logic [DIV_DVD_W-1:0]    div_dividend;
  logic [DIV_DVS_W-1:0]    div_divisor;
  logic [DIV_DVD_W-1:0]    div_quotient;

  logic                    in_xfer;
  logic [STEP_W-1:0]       step_count_next;
  logic                    stop_next;
  logic [PLAN_CODE_W-1:0]  plan_code;
  logic [IDXW-1:0]         plan_index_next;
  logic [LEVEL_W-1:0]      level_down;
  logic [RATE_W+1:0]       dec_sum;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  always_comb begin
    step_count_next = step_count + 1'b1;
    stop_next = step_count_next > total_steps;
    plan_code = '0;
    for (int k = 0; k < PLAN_ENTRIES; k++) begin
      if (k < PLAN_DEPTH && plan_index == IDXW'(k)) begin
        plan_code = phase_plan[PLAN_CODE_W*k +: PLAN_CODE_W];
      end
    end
    plan_index_next = (plan_index == IDXW'(PLAN_DEPTH - 1)) ? '0 : plan_index + 1'b1;
    level_down = (ramp_level != '0) ? ramp_level - 1'b1 : '0;
    dec_sum = {2'b00, interval} + {1'b0, div_quotient};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_steps <= '0;
      accel_end_step <= '0;
      decel_start_step <= '0;
      cruise_rate <= '0;
      top_level <= '0;
      end_level <= '0;
      end_rate <= '0;
      phase_plan <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TOTAL_STEPS: total_steps <= cfg_data;
        REG_ACCEL_END: accel_end_step <= cfg_data;
        REG_DECEL_START: decel_start_step <= cfg_data;
        REG_CRUISE_RATE: cruise_rate <= cfg_data[RATE_W-1:0];
        REG_TOP_LEVEL: top_level <= cfg_data[LEVEL_W-1:0];
        REG_END_LEVEL: end_level <= cfg_data[LEVEL_W-1:0];
        REG_END_RATE: end_rate <= cfg_data[RATE_W-1:0];
        REG_PHASE_PLAN: phase_plan <= cfg_data[PLAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step_count <= '0;
      interval <= '0;
      ramp_level <= '0;
      plan_index <= '0;
      saved_accel_rate <= '0;
      axis_position <= '0;
      reverse_dir <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (s_axis_tuser == ACT_START) begin
              interval <= s_axis_tdata[RATE_W-1:0];
              reverse_dir <= s_axis_tdata[RATE_W];
              step_count <= '0;
              plan_index <= '0;
              ramp_level <= '0;
              res_period <= s_axis_tdata[RATE_W-1:0];
              res_stop <= 1'b0;
              state <= S_DONE;
            end else begin
              step_count <= step_count_next;
              res_stop <= stop_next;
              res_period <= stop_next ? '0 : interval;
              if (!stop_next) begin
                axis_position <= reverse_dir ? axis_position - 1'b1 : axis_position + 1'b1;
              end
              state <= S_PHASE;
            end
          end
        end
        S_PHASE: begin
          state <= S_DONE;
          case (plan_code)
            PH_ACCEL: begin
              if (accel_end_step <= step_count) begin
                plan_index <= plan_index_next;
                saved_accel_rate <= interval;
                interval <= cruise_rate;
                ramp_level <= top_level;
              end else if (ramp_level < top_level) begin
                ramp_level <= ramp_level + 1'b1;
                if (ramp_level == '0) begin
                  mul_start <= 1'b1;
                  state <= S_MUL;
                end else begin
                  div_dividend <= {interval, 1'b0};
                  div_divisor <= {ramp_level + 1'b1, 2'b01};
                  div_sub <= 1'b1;
                  div_start <= 1'b1;
                  state <= S_DIV;
                end
              end
            end
            PH_CRUISE, PH_CRUISE_ALT: begin
              if (step_count >= decel_start_step) begin
                plan_index <= plan_index_next;
                interval <= saved_accel_rate;
                ramp_level <= level_down;
              end
            end
            PH_DECEL: begin
              ramp_level <= level_down;
              if (level_down > end_level) begin
                div_dividend <= {interval, 1'b0};
                div_divisor <= {level_down, 2'b01};
                div_sub <= 1'b0;
                div_start <= 1'b1;
                state <= S_DIV;
              end else begin
                interval <= end_rate;
              end
            end
            default: ;
          endcase
        end
        S_MUL: begin
          if (mul_done) begin
            interval <= mul_product;
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_sub) begin
              interval <= interval - div_quotient[RATE_W-1:0];
            end else if (dec_sum > (RATE_W + 2)'(RATE_MAX)) begin
              interval <= RATE_MAX;
            end else begin
              interval <= dec_sum[RATE_W-1:0];
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {axis_position, res_period};
      m_axis_tuser <= res_stop;
      m_axis_tlast <= res_stop;
    end
  end

  srst_serial_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (interval),
    .done         (mul_done),
    .product_q16  (mul_product)
  );

  srst_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the stepper ramp step timer core.
`timescale 1ns / 1ps

module testbench;
  import srst_pkg::*;

  localparam int PLAN_DEPTH = PLAN_DEPTH_DEFAULT;
  localparam logic [PLAN_CODE_W-1:0] PH_IDLE = 3'd0;
  localparam logic [PLAN_CODE_W-1:0] PH_SPARE4 = 3'd4;
  localparam logic [PLAN_CODE_W-1:0] PH_SPARE6 = 3'd6;
  localparam logic [PLAN_CODE_W-1:0] PH_SPARE7 = 3'd7;

  typedef struct packed {
    logic              action;
    logic [RATE_W-1:0] rate;
    logic              reverse;
  } step_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] period;
    logic              stop;
    logic              done;
    logic [POS_W-1:0]  position;
  } timer_load_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  stepper_ramp_step_timer_core u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [STEP_W-1:0]  reg_total = '0;
  logic [STEP_W-1:0]  reg_accel_end = '0;
  logic [STEP_W-1:0]  reg_decel_start = '0;
  logic [RATE_W-1:0]  reg_cruise = '0;
  logic [LEVEL_W-1:0] reg_top = '0;
  logic [LEVEL_W-1:0] reg_end_level = '0;
  logic [RATE_W-1:0]  reg_end_rate = '0;
  logic [PLAN_W-1:0]  reg_plan = '0;

  logic [STEP_W-1:0]  steps_taken = '0;
  logic [RATE_W-1:0]  cur_interval = '0;
  logic [LEVEL_W-1:0] level = '0;
  int                 plan_pos = 0;
  logic [RATE_W-1:0]  held_rate = '0;
  logic [POS_W-1:0]   axis_pos = '0;
  logic               backward = 1'b0;

  step_item_t  pending_steps[$];
  timer_load_t expected_loads[$];
  step_item_t  drive_item;
  int items_queued = 0;
  int items_accepted = 0;
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic in_taken = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;

  function automatic timer_load_t next_timer_load(input logic act,
                                                  input logic [RATE_W-1:0] rate,
                                                  input logic rev);
    timer_load_t r;
    logic [PLAN_CODE_W-1:0] code;
    logic [63:0] wide;
    r = '0;
    if (act == ACT_START) begin
      cur_interval = rate;
      backward = rev;
      steps_taken = '0;
      plan_pos = 0;
      level = '0;
      r.period = cur_interval;
      r.position = axis_pos;
      return r;
    end
    steps_taken = steps_taken + 1'b1;
    if (steps_taken > reg_total) begin
      r.stop = 1'b1;
      r.done = 1'b1;
    end else begin
      r.period = cur_interval;
      axis_pos = backward ? axis_pos - 1'b1 : axis_pos + 1'b1;
    end
    code = reg_plan[plan_pos*PLAN_CODE_W +: PLAN_CODE_W];
    if (code == PH_ACCEL) begin
      if (reg_accel_end <= steps_taken) begin
        plan_pos = (plan_pos + 1) % PLAN_DEPTH;
        held_rate = cur_interval;
        cur_interval = reg_cruise;
        level = reg_top;
      end else if (level < reg_top) begin
        level = level + 1'b1;
        if (level == 1) begin
          wide = 64'(cur_interval) * 64'(FIRST_STEP_Q16);
          cur_interval = wide[RATE_W+15:16];
        end else begin
          wide = (64'(cur_interval) * 2) / (64'(level) * 4 + 1);
          cur_interval = cur_interval - wide[RATE_W-1:0];
        end
      end
    end else if (code == PH_CRUISE || code == PH_CRUISE_ALT) begin
      if (steps_taken >= reg_decel_start) begin
        plan_pos = (plan_pos + 1) % PLAN_DEPTH;
        cur_interval = held_rate;
        if (level != 0) level = level - 1'b1;
      end
    end else if (code == PH_DECEL) begin
      if (level != 0) level = level - 1'b1;
      if (level > reg_end_level) begin
        wide = 64'(cur_interval) + (64'(cur_interval) * 2) / (64'(level) * 4 + 1);
        cur_interval = (wide > 64'(RATE_MAX)) ? RATE_MAX : wide[RATE_W-1:0];
      end else begin
        cur_interval = reg_end_rate;
      end
    end
    r.position = axis_pos;
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
    end
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) return RATE_MAX;
    if (sel < 30) return RATE_W'($urandom_range(0, 255));
    return RATE_W'($urandom);
  endfunction

  task automatic queue_step(input logic act, input logic [RATE_W-1:0] rate,
                            input logic rev);
    step_item_t it;
    it.action = act;
    it.rate = rate;
    it.reverse = rev;
    pending_steps.push_back(it);
    items_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (items_accepted != items_queued || expected_loads.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TOTAL_STEPS: reg_total = value;
      REG_ACCEL_END: reg_accel_end = value;
      REG_DECEL_START: reg_decel_start = value;
      REG_CRUISE_RATE: reg_cruise = value[RATE_W-1:0];
      REG_TOP_LEVEL: reg_top = value[LEVEL_W-1:0];
      REG_END_LEVEL: reg_end_level = value[LEVEL_W-1:0];
      REG_END_RATE: reg_end_rate = value[RATE_W-1:0];
      REG_PHASE_PLAN: reg_plan = value[PLAN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] total, input logic [31:0] accel_end,
                           input logic [31:0] decel_start, input logic [31:0] cruise,
                           input logic [31:0] top, input logic [31:0] end_level,
                           input logic [31:0] end_rate, input logic [31:0] plan);
    write_reg(REG_TOTAL_STEPS, total);
    write_reg(REG_ACCEL_END, accel_end);
    write_reg(REG_DECEL_START, decel_start);
    write_reg(REG_CRUISE_RATE, cruise);
    write_reg(REG_TOP_LEVEL, top);
    write_reg(REG_END_LEVEL, end_level);
    write_reg(REG_END_RATE, end_rate);
    write_reg(REG_PHASE_PLAN, plan);
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (pending_steps.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drive_item = pending_steps.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, drive_item.reverse, drive_item.rate};
        s_axis_tuser <= drive_item.action;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    timer_load_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_loads.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result expected none actual tdata %h stop %b done %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          want = expected_loads.pop_front();
          check_field("timer_period", 32'(want.period), 32'(m_axis_tdata[RATE_W-1:0]));
          check_field("position", want.position, m_axis_tdata[RATE_W +: POS_W]);
          check_field("timer_stop", 32'(want.stop), 32'(m_axis_tuser));
          check_field("block_done", 32'(want.done), 32'(m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_loads.push_back(next_timer_load(s_axis_tuser, s_axis_tdata[RATE_W-1:0],
                                                 s_axis_tdata[RATE_W]));
        items_accepted++;
      end
    end
  end

  initial begin
    logic [31:0] total, accel_end, decel_start, top, end_level;
    logic [PLAN_W-1:0] plan;
    int phase, phase_items, sel, n;
    logic paused;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 48;

    queue_step(ACT_START, 24'h5A5A5A, 1'b1);
    queue_step(ACT_TICK, 24'hA5A5A5, 1'b0);
    wait_idle();

    configure(5, 3, 4, 32'h00002000, 3, 1, 32'h000ABCDE,
              32'({PH_IDLE, PH_SPARE6, PH_SPARE7, PH_SPARE4,
                   PH_CRUISE_ALT, PH_DECEL, PH_CRUISE, PH_ACCEL}));
    queue_step(ACT_START, RATE_MAX, 1'b0);
    repeat (7) queue_step(ACT_TICK, 24'(RATE_W'($urandom)), 1'b1);
    queue_step(ACT_START, '0, 1'b1);
    repeat (2) queue_step(ACT_TICK, '0, 1'b0);
    wait_idle();

    configure(32'hFFFFFFFF, 1, 0, 32'(RATE_MAX), 32'h0000FFFF, 0, 32'(RATE_MAX),
              32'({PH_IDLE, PH_IDLE, PH_IDLE, PH_DECEL,
                   PH_DECEL, PH_DECEL, PH_CRUISE_ALT, PH_ACCEL}));
    queue_step(ACT_START, RATE_MAX, 1'b1);
    repeat (5) queue_step(ACT_TICK, RATE_MAX, 1'b1);
    queue_step(ACT_START, 24'h000001, 1'b0);
    repeat (2) queue_step(ACT_TICK, '0, 1'b0);
    wait_idle();

    configure(1, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 32'h0000FFFF, 0,
              32'({PH_IDLE, PH_IDLE, PH_IDLE, PH_IDLE,
                   PH_IDLE, PH_IDLE, PH_CRUISE, PH_DECEL}));
    queue_step(ACT_START, 24'h800000, 1'b0);
    repeat (2) queue_step(ACT_TICK, '0, 1'b0);

    for (phase = 0; phase < 10; phase++) begin
      if (phase < 4) begin
        send_idle_pct = 36;
        recv_idle_pct = 48;
      end else if (phase < 8) begin
        send_idle_pct = 48;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_idle();

      sel = $urandom_range(0, 9);
      total = (sel < 8) ? $urandom_range(0, 40) : (sel == 8) ? 32'hFFFFFFFF : $urandom;
      sel = $urandom_range(0, 9);
      accel_end = (sel < 8) ? $urandom_range(0, 20) : (sel == 8) ? 32'hFFFFFFFF : $urandom;
      decel_start = ($urandom_range(0, 9) < 8) ? accel_end + $urandom_range(0, 15) : $urandom;
      sel = $urandom_range(0, 9);
      top = (sel < 7) ? $urandom_range(0, 20) : (sel == 7) ? 32'hFFFF : $urandom_range(0, 65535);
      end_level = ($urandom_range(0, 9) < 8) ? $urandom_range(0, top) : $urandom_range(0, 65535);
      plan = PLAN_W'($urandom);
      if ($urandom_range(0, 9) < 7) begin
        plan[2:0] = PH_ACCEL;
        plan[5:3] = $urandom_range(0, 1) ? PH_CRUISE : PH_CRUISE_ALT;
        plan[8:6] = PH_DECEL;
      end
      configure(total, accel_end, decel_start, 32'(pick_rate()), top, end_level,
                32'(pick_rate()), 32'(plan));

      if (phase == 2) hold_req = 1'b1;
      phase_items = 0;
      paused = 1'b0;
      while (phase_items < 80) begin
        if (phase == 5 && !paused && phase_items > 40) begin
          wait_idle();
          paused = 1'b1;
        end
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
          n = (total <= 40) ? total + $urandom_range(0, 3) : $urandom_range(3, 40);
          queue_step(ACT_START, pick_rate(), 1'($urandom_range(0, 1)));
          repeat (n) queue_step(ACT_TICK, RATE_W'($urandom), 1'($urandom_range(0, 1)));
          phase_items += n + 1;
        end else if (sel < 90) begin
          n = $urandom_range(0, 3);
          queue_step(ACT_START, pick_rate(), 1'($urandom_range(0, 1)));
          repeat (n) queue_step(ACT_TICK, RATE_W'($urandom), 1'($urandom_range(0, 1)));
          phase_items += n + 1;
        end else begin
          queue_step(1'($urandom_range(0, 1)), RATE_W'($urandom), 1'($urandom_range(0, 1)));
          phase_items++;
        end
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && expected_loads.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
